// ----- rtl/udmn_pkg.sv -----
// ----------------------------------------------------------------------------
// udmn_pkg
// shared constants and control/status types of the magic number generator
// ----------------------------------------------------------------------------
package udmn_pkg;

  localparam int unsigned DataWidth  = 64;
  localparam int unsigned ShiftWidth = 7;
  localparam int unsigned PWidth     = 8;
  localparam int unsigned CntWidth   = 6;

  // quotient bits of 2^63-1 by d, one per restoring step
  localparam logic [CntWidth-1:0]  DivLastIdx = CntWidth'(62);

  localparam logic [DataWidth-1:0] HalfMaxMinus = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataWidth-1:0] TopBit       = 64'h8000_0000_0000_0000;
  localparam logic [PWidth-1:0]    StartP       = 8'd63;
  localparam logic [PWidth-1:0]    EndP         = 8'd128;
  localparam logic [PWidth-1:0]    ShiftBase    = 8'd64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic srch_step;
  } udmn_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic zero;
    logic div_last;
    logic srch_more;
  } udmn_sts_t;

endpackage

// ----- rtl/udmn_dpath.sv -----
// ----------------------------------------------------------------------------
// udmn_dpath
// restoring divider and doubling search registers of the magic number unit
// ----------------------------------------------------------------------------
module udmn_dpath import udmn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  udmn_cmd_t             cmd_i,
  output udmn_sts_t             sts_o,
  input  logic [DataWidth-1:0]  divisor_i,
  output logic [DataWidth-1:0]  magic_o,
  output logic [ShiftWidth-1:0] post_shift_o,
  output logic                  add_needed_o,
  output logic                  bad_divisor_o
);

  logic [DataWidth-1:0] d_q, d_d;
  logic [DataWidth-1:0] q_q, q_d;
  logic [DataWidth-1:0] r_q, r_d;
  logic [DataWidth-1:0] pw_q, pw_d;
  logic [DataWidth-1:0] delta_q, delta_d;
  logic [PWidth-1:0]    p_q, p_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 add_q, add_d;
  logic                 bad_q, bad_d;

  // divider step
  logic [DataWidth:0]   rem_ext;
  logic                 div_ge;
  logic [DataWidth:0]   rem_sub;

  // search step
  logic [DataWidth-1:0] r_inc;
  logic [DataWidth-1:0] d_minus_r;
  logic [DataWidth-1:0] dmr1;
  logic [DataWidth-1:0] twice_r1;
  logic                 up;

  assign rem_ext  = {r_q, 1'b1};
  assign div_ge   = rem_ext >= {1'b0, d_q};
  assign rem_sub  = rem_ext - {1'b0, d_q};

  assign r_inc     = r_q + DataWidth'(1);
  assign d_minus_r = d_q - r_q;
  assign dmr1      = d_minus_r - DataWidth'(1);
  assign twice_r1  = {r_q[DataWidth-2:0], 1'b1};
  assign up        = r_inc >= d_minus_r;

  always_comb begin
    d_d     = d_q;
    q_d     = q_q;
    r_d     = r_q;
    pw_d    = pw_q;
    delta_d = delta_q;
    p_d     = p_q;
    cnt_d   = cnt_q;
    add_d   = add_q;
    bad_d   = bad_q;
    if (cmd_i.load) begin
      d_d     = divisor_i;
      q_d     = '0;
      r_d     = '0;
      pw_d    = '0;
      delta_d = '0;
      p_d     = StartP;
      cnt_d   = DivLastIdx;
      add_d   = 1'b0;
      bad_d   = divisor_i == '0;
    end else if (cmd_i.div_step) begin
      q_d   = {q_q[DataWidth-2:0], div_ge};
      r_d   = div_ge ? rem_sub[DataWidth-1:0] : twice_r1;
      cnt_d = cnt_q - CntWidth'(1);
    end else if (cmd_i.srch_step) begin
      p_d  = p_q + PWidth'(1);
      pw_d = (p_q == StartP) ? DataWidth'(1) : {pw_q[DataWidth-2:0], 1'b0};
      if (up) begin
        if (q_q >= HalfMaxMinus) add_d = 1'b1;
        q_d     = {q_q[DataWidth-2:0], 1'b1};
        r_d     = twice_r1 - d_q;
        // d-1-(2r+1-d) = 2(d-r-1)
        delta_d = {dmr1[DataWidth-2:0], 1'b0};
      end else begin
        if (q_q >= TopBit) add_d = 1'b1;
        q_d     = {q_q[DataWidth-2:0], 1'b0};
        r_d     = twice_r1;
        // d-1-(2r+1) = (d-r-1)-(r+1)
        delta_d = dmr1 - r_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    q_q     <= q_d;
    r_q     <= r_d;
    pw_q    <= pw_d;
    delta_q <= delta_d;
    p_q     <= p_d;
    add_q   <= add_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bad_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      bad_q <= bad_d;
    end
  end

  assign sts_o.zero      = divisor_i == '0;
  assign sts_o.div_last  = cnt_q == '0;
  assign sts_o.srch_more = (p_q < EndP) && (pw_q < delta_q);

  logic [PWidth-1:0] shift_full;
  assign shift_full = p_q - ShiftBase;

  assign magic_o       = bad_q ? '0 : q_q + DataWidth'(1);
  assign post_shift_o  = bad_q ? '0 : shift_full[ShiftWidth-1:0];
  assign add_needed_o  = bad_q ? 1'b0 : add_q;
  assign bad_divisor_o = bad_q;

endmodule

// ----- rtl/udmn_ctrl.sv -----
// ----------------------------------------------------------------------------
// udmn_ctrl
// sequencer: load, divide, doubling search, result strobe
// ----------------------------------------------------------------------------
module udmn_ctrl import udmn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      valid_o,
  output udmn_cmd_t cmd_o,
  input  udmn_sts_t sts_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StFirst = 3'd2;
  localparam logic [2:0] StSrch  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.zero ? StDone : StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StFirst;
      end
      StFirst: begin
        // first doubling step is unconditional
        cmd_o.srch_step = 1'b1;
        state_d         = StSrch;
      end
      StSrch: begin
        if (sts_i.srch_more) begin
          cmd_o.srch_step = 1'b1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = state_q != StIdle;
  assign valid_o = state_q == StDone;

endmodule

// ----- rtl/unsigned_div_magic_number.sv -----
// ----------------------------------------------------------------------------
// unsigned_div_magic_number
// magic multiplier, post-shift and add flag for a 64-bit unsigned divisor
// ----------------------------------------------------------------------------
// sequence: load, the restoring divide steps, the doubling search steps, a check,
//   then the result strobe; a zero divisor goes from load straight to the result
// throughput: one divisor at a time, next start taken the cycle after valid_o
// the divide loop (one quotient bit per cycle) and the search loop (one
//   doubling per cycle) share one set of 64-bit registers
// reset: asynchronous active low, clears the sequencer to idle; the receiver
//   cannot stall, each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module unsigned_div_magic_number import udmn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command side: transfer when start is high and busy is low
  input  logic                  start,
  output logic                  busy,
  input  logic [DataWidth-1:0]  divisor_i,
  // result side: one-cycle strobe
  output logic                  valid_o,
  output logic [DataWidth-1:0]  magic_o,
  output logic [ShiftWidth-1:0] post_shift_o,
  output logic                  add_needed_o,
  output logic                  bad_divisor_o
);

  udmn_cmd_t cmd;
  udmn_sts_t sts;

  // sequencer: idle -> divide -> search -> result, or idle -> result for a zero divisor
  udmn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  // divider and search registers; result fields held stable while idle
  udmn_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .divisor_i     (divisor_i),
    .magic_o       (magic_o),
    .post_shift_o  (post_shift_o),
    .add_needed_o  (add_needed_o),
    .bad_divisor_o (bad_divisor_o)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the unsigned 64-bit divide magic number generator:
// directed and random divisors go in through the start/busy command port, and
// every valid_o strobe is checked against an in-bench magicu2 search
// ----------------------------------------------------------------------------
module tb;
  import udmn_pkg::*;

  // one result of the block, as seen on the strobe
  typedef struct packed {
    logic [DataWidth-1:0]  magic;
    logic [ShiftWidth-1:0] post_shift;
    logic                  add_needed;
    logic                  bad_divisor;
  } magic_res_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts the magic triple of each accepted divisor and keeps
  // the predictions in order until the matching strobe shows up
  // --------------------------------------------------------------------------
  class magic_scoreboard;
    magic_res_t  pending_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // magicu2 search over 64-bit words, all arithmetic wraps at 2^64
    function magic_res_t predict_magic(input logic [DataWidth-1:0] d);
      magic_res_t           res;
      logic [DataWidth-1:0] quo, rem, pw, delta;
      int unsigned          p;
      logic                 add;
      res = '0;
      if (d == '0) begin
        res.bad_divisor = 1'b1;
        return res;
      end
      p   = StartP;
      quo = HalfMaxMinus / d;
      rem = HalfMaxMinus - quo * d;
      pw  = 64'd1;
      add = 1'b0;
      do begin
        p++;
        if (p == ShiftBase) begin
          pw = 64'd1;
        end else begin
          pw = pw << 1;
        end
        if (rem + 64'd1 >= d - rem) begin
          if (quo >= HalfMaxMinus) add = 1'b1;
          quo = (quo << 1) + 64'd1;
          rem = (rem << 1) + 64'd1 - d;
        end else begin
          if (quo >= TopBit) add = 1'b1;
          quo = quo << 1;
          rem = (rem << 1) + 64'd1;
        end
        delta = d - 64'd1 - rem;
      end while (p < EndP && pw < delta);
      // divisor one wraps quo + 1 to zero, same as the C arithmetic
      res.magic      = quo + 64'd1;
      res.post_shift = ShiftWidth'(p - ShiftBase);
      res.add_needed = add;
      return res;
    endfunction

    function void note_divisor(input logic [DataWidth-1:0] d);
      pending_q.push_back(predict_magic(d));
    endfunction

    function void check_result(input magic_res_t got);
      magic_res_t exp_res;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: magic %h shift %0d add %b bad %b", $realtime,
                   got.magic, got.post_shift, got.add_needed, got.bad_divisor);
        mismatches++;
        return;
      end
      exp_res = pending_q.pop_front();
      if (got.magic !== exp_res.magic || got.post_shift !== exp_res.post_shift ||
          got.add_needed !== exp_res.add_needed || got.bad_divisor !== exp_res.bad_divisor) begin
        if (mismatches < 10)
          $display("[%0t] mismatch: magic %h/%h shift %0d/%0d add %b/%b bad %b/%b (exp/act)",
                   $realtime, exp_res.magic, got.magic, exp_res.post_shift, got.post_shift,
                   exp_res.add_needed, got.add_needed, exp_res.bad_divisor, got.bad_divisor);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [DataWidth-1:0]  divisor_i;
  logic                  valid_o;
  logic [DataWidth-1:0]  magic_o;
  logic [ShiftWidth-1:0] post_shift_o;
  logic                  add_needed_o;
  logic                  bad_divisor_o;

  magic_scoreboard       sb;
  magic_res_t            seen_res;
  logic [DataWidth-1:0]  directed_q[$];
  int unsigned           sender_idle_pct[3] = '{15, 47, 0};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  unsigned_div_magic_number u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .divisor_i     (divisor_i),
    .valid_o       (valid_o),
    .magic_o       (magic_o),
    .post_shift_o  (post_shift_o),
    .add_needed_o  (add_needed_o),
    .bad_divisor_o (bad_divisor_o)
  );

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // raise start with the divisor and hold both until the block takes the
  // transfer; start is left high so back-to-back commands need no extra edge
  task automatic send_divisor(input logic [DataWidth-1:0] d);
    start     <= 1'b1;
    divisor_i <= d;
    do @(posedge clk_i); while (busy);
    sb.note_divisor(d);
  endtask

  // drop start for a while, with junk on the data lines since nothing samples them
  task automatic sender_pause(input int unsigned n);
    start     <= 1'b0;
    divisor_i <= {$urandom, $urandom};
    repeat (n) @(posedge clk_i);
  endtask

  // hold off until every predicted result has been seen; always moves at least
  // one edge so start is never lowered and raised within one step
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  // random divisor, shaped toward the interesting corners: short operands
  // (long search), values around powers of two (exact shifts and add cases),
  // and the very top of the range
  function automatic logic [DataWidth-1:0] rand_divisor();
    logic [DataWidth-1:0] v;
    int unsigned          kind;
    v    = {$urandom, $urandom};
    kind = $urandom_range(99);
    if (kind < 30) return v;
    else if (kind < 65) return v >> $urandom_range(63);
    else if (kind < 80) return (64'd1 << $urandom_range(63)) + 64'($urandom_range(6)) - 64'd3;
    else if (kind < 90) return 64'($urandom_range(1000));
    else return ~64'($urandom_range(1000));
  endfunction

  // a gap now and then, long enough to land anywhere in the run
  // of the command in flight or past its strobe
  task automatic maybe_idle(input int unsigned pct);
    if ($urandom_range(99) < pct) sender_pause($urandom_range(140, 1));
  endtask

  // --------------------------------------------------------------------------
  // result side: the strobe cannot be held off, so just watch it
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      seen_res.magic       = magic_o;
      seen_res.post_shift  = post_shift_o;
      seen_res.add_needed  = add_needed_o;
      seen_res.bad_divisor = bad_divisor_o;
      sb.check_result(seen_res);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb        = new();
    rst_ni    = 1'b0;
    start     = 1'b0;
    divisor_i = '0;

    // zero divisor, divisor one, small and odd divisors, exact powers of two,
    // neighbors of 2^32 and 2^63, top of the range, alternating bit patterns
    directed_q = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd5, 64'd6, 64'd7, 64'd10, 64'd641,
                   64'd274177, 64'd1000000007, 64'h1_0000_0000, 64'h1_0000_0001,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_FFFF_FFFF};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_q[i]) begin
      maybe_idle(sender_idle_pct[0]);
      send_divisor(directed_q[i]);
    end
    drain_results();

    // three phases of random divisors: light sender gaps, heavy gaps, none;
    // a full drain between phases exercises an idle block taking a new command
    for (int ph = 0; ph < 3; ph++) begin
      repeat (567) begin
        maybe_idle(sender_idle_pct[ph]);
        send_divisor(rand_divisor());
      end
      drain_results();
    end

    // quiet tail, long enough for any stray strobe to show up
    repeat (200) @(posedge clk_i);
    if (sb.pending_q.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_q.size());
      sb.mismatches++;
    end

    if (sb.mismatches == 0) begin
      $display("** unsigned_div_magic_number: PASSED **");
    end else begin
      $display("** unsigned_div_magic_number: FAILED **");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout");
    $display("** unsigned_div_magic_number: FAILED **");
    $finish;
  end

endmodule
